FILE: hdl/pidts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_pkg
// Types, constants and saturation helpers for the timestamped PID unit.
// ----------------------------------------------------------------------------
package pidts_pkg;

  localparam int DataWidth   = 32;
  localparam int FracBits    = 16;
  localparam int ProdWidth   = 2 * DataWidth;
  localparam int QuotWidth   = DataWidth + FracBits;
  localparam int DivCntWidth = $clog2(QuotWidth);
  localparam int CfgIdxWidth = 3;

  localparam logic signed [DataWidth-1:0] MaxVal = {1'b0, {(DataWidth-1){1'b1}}};
  localparam logic signed [DataWidth-1:0] MinVal = {1'b1, {(DataWidth-1){1'b0}}};
  localparam logic [DataWidth-1:0]        TickPeriodRst = 32'd4294967;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_TARGET = 3'd0,
    CFG_KP     = 3'd1,
    CFG_KI     = 3'd2,
    CFG_KD     = 3'd3,
    CFG_WINDUP = 3'd4,
    CFG_DMIN   = 3'd5,
    CFG_DMAX   = 3'd6,
    CFG_TICK   = 3'd7
  } pidts_cfg_e;

  typedef enum logic [2:0] {
    MS_TICK  = 3'd0,
    MS_PROP  = 3'd1,
    MS_EDT   = 3'd2,
    MS_INTEG = 3'd3,
    MS_DERIV = 3'd4
  } pidts_mul_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TDT,
    ST_PROP,
    ST_EDT,
    ST_INTEG,
    ST_MUL_I,
    ST_CAP_I,
    ST_DIV,
    ST_OUT
  } pidts_state_e;

  typedef struct packed {
    logic           accept;
    logic           ld_diff;
    logic           mul_en;
    pidts_mul_sel_e mul_sel;
    logic           ld_dt;
    logic           ld_p;
    logic           ld_integ;
    logic           ld_pi;
    logic           div_start;
    logic           ld_out;
  } pidts_cmd_t;

  typedef struct packed {
    logic first;
    logic dt_zero;
    logic div_busy;
  } pidts_sts_t;

  function automatic logic signed [DataWidth-1:0] sat_add(
    input logic signed [DataWidth:0] v
  );
    if (v[DataWidth] != v[DataWidth-1]) begin
      return v[DataWidth] ? MinVal : MaxVal;
    end
    return v[DataWidth-1:0];
  endfunction

  function automatic logic [DataWidth-1:0] mag(input logic signed [DataWidth-1:0] v);
    logic [DataWidth-1:0] u;
    u = v;
    return v[DataWidth-1] ? (~u + 1'b1) : u;
  endfunction

  function automatic logic [DataWidth-1:0] mag_sat(
    input logic                 neg,
    input logic [QuotWidth-1:0] m
  );
    logic [DataWidth-1:0] lim;
    lim = neg ? MinVal : MaxVal;
    return (m > {{FracBits{1'b0}}, lim}) ? lim : m[DataWidth-1:0];
  endfunction

  function automatic logic signed [DataWidth-1:0] qsat(
    input logic                 neg,
    input logic [QuotWidth-1:0] m
  );
    logic [DataWidth-1:0] s;
    s = mag_sat(neg, m);
    return neg ? signed'(~s + 1'b1) : signed'(s);
  endfunction

endpackage

FILE: hdl/pidts_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_in_if
// Sample request channel: feedback value and tick timestamp.
// ----------------------------------------------------------------------------
interface pidts_in_if import pidts_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] measured;
  logic [DataWidth-1:0]        sample_time;

  modport source (output valid, measured, sample_time, input ready);
  modport sink   (input valid, measured, sample_time, output ready);
endinterface

FILE: hdl/pidts_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_out_if
// Result request channel: clamped controller drive.
// ----------------------------------------------------------------------------
interface pidts_out_if import pidts_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [DataWidth-1:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

FILE: hdl/pidts_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pidts_div import pidts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [QuotWidth-1:0]   dividend_i,
  input  logic [DataWidth-2:0]   divisor_i,
  output logic [QuotWidth-1:0]   quotient_o,
  output logic                   busy_o
);

  logic                   busy_q, busy_d;
  logic [DivCntWidth-1:0] cnt_q, cnt_d;
  logic [DataWidth-2:0]   rem_q, rem_d;
  logic [QuotWidth-1:0]   quo_q, quo_d;
  logic [DataWidth-2:0]   den_q;
  logic [DataWidth-1:0]   trial;
  logic [DataWidth-1:0]   diff;
  logic                   ge;

  assign trial = {rem_q, quo_q[QuotWidth-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntWidth'(QuotWidth - 1);
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DataWidth-2:0] : trial[DataWidth-2:0];
      quo_d = {quo_q[QuotWidth-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      den_q <= divisor_i;
    end
  end

  assign quotient_o = quo_q;
  assign busy_o     = busy_q;

endmodule

FILE: hdl/pidts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_datapath
// Config registers, loop state, shared 32x32 multiplier and derivative divider.
// ----------------------------------------------------------------------------
module pidts_datapath import pidts_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [DataWidth-1:0]        cfg_data_i,
  input  logic signed [DataWidth-1:0] measured_i,
  input  logic [DataWidth-1:0]        sample_time_i,
  input  pidts_cmd_t                  cmd_i,
  output pidts_sts_t                  sts_o,
  output logic signed [DataWidth-1:0] drive_o
);

  // configuration
  logic signed [DataWidth-1:0] target_q, kp_q, ki_q, kd_q, dmin_q, dmax_q;
  logic [DataWidth-2:0]        windup_q;
  logic [DataWidth-1:0]        tick_q;

  // loop state
  logic [DataWidth-1:0]        last_time_q;
  logic signed [DataWidth-1:0] last_err_q;
  logic signed [DataWidth-1:0] integ_q, integ_d;

  // per-sample working registers
  logic [DataWidth-1:0]        ticks_q;
  logic signed [DataWidth-1:0] err_q, diff_q, p_q, pi_q, drive_q;
  logic [DataWidth-2:0]        dt_q, dt_d;
  logic [ProdWidth-1:0]        prod_q;
  logic                        mul_neg_q;

  logic [DataWidth-1:0]        mul_a, mul_b;
  logic                        mul_neg;
  logic [QuotWidth-1:0]        prod_sh;
  logic signed [DataWidth-1:0] cap;
  logic signed [DataWidth-1:0] integ_sum, lim_pos, lim_neg;
  logic signed [DataWidth-1:0] d_term, y_sum, y_clamp;
  logic [QuotWidth-1:0]        quotient;
  logic [DataWidth-1:0]        dq_mag;
  logic                        div_busy;

  assign prod_sh = prod_q[ProdWidth-1:FracBits];
  assign cap     = qsat(mul_neg_q, prod_sh);
  assign dq_mag  = mag_sat(diff_q[DataWidth-1], quotient);

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_TICK: begin
        mul_a   = ticks_q;
        mul_b   = tick_q;
        mul_neg = 1'b0;
      end
      MS_PROP: begin
        mul_a   = mag(err_q);
        mul_b   = mag(kp_q);
        mul_neg = err_q[DataWidth-1] ^ kp_q[DataWidth-1];
      end
      MS_EDT: begin
        mul_a   = mag(err_q);
        mul_b   = {1'b0, dt_q};
        mul_neg = err_q[DataWidth-1];
      end
      MS_INTEG: begin
        mul_a   = mag(integ_q);
        mul_b   = mag(ki_q);
        mul_neg = integ_q[DataWidth-1] ^ ki_q[DataWidth-1];
      end
      MS_DERIV: begin
        mul_a   = dq_mag;
        mul_b   = mag(kd_q);
        mul_neg = diff_q[DataWidth-1] ^ kd_q[DataWidth-1];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign dt_d = (prod_sh > {{(FracBits + 1){1'b0}}, {(DataWidth-1){1'b1}}})
              ? {(DataWidth-1){1'b1}} : prod_sh[DataWidth-2:0];

  // anti-windup clamp
  assign integ_sum = sat_add({integ_q[DataWidth-1], integ_q} + {cap[DataWidth-1], cap});
  assign lim_pos   = signed'({1'b0, windup_q});
  assign lim_neg   = -lim_pos;

  always_comb begin
    if (integ_sum > lim_pos) begin
      integ_d = lim_pos;
    end else if (integ_sum < lim_neg) begin
      integ_d = lim_neg;
    end else begin
      integ_d = integ_sum;
    end
  end

  // output sum and clamp; with crossed limits, sums above the max give the max, all others the min
  assign d_term = sts_o.dt_zero ? '0 : cap;
  assign y_sum  = sat_add({pi_q[DataWidth-1], pi_q} + {d_term[DataWidth-1], d_term});

  always_comb begin
    if (y_sum > dmax_q) begin
      y_clamp = dmax_q;
    end else if (y_sum < dmin_q) begin
      y_clamp = dmin_q;
    end else begin
      y_clamp = y_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      kp_q        <= '0;
      ki_q        <= '0;
      kd_q        <= '0;
      windup_q    <= '0;
      dmin_q      <= '0;
      dmax_q      <= '0;
      tick_q      <= TickPeriodRst;
      last_time_q <= '0;
      last_err_q  <= '0;
      integ_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (pidts_cfg_e'(cfg_idx_i))
          CFG_TARGET: target_q <= cfg_data_i;
          CFG_KP:     kp_q     <= cfg_data_i;
          CFG_KI:     ki_q     <= cfg_data_i;
          CFG_KD:     kd_q     <= cfg_data_i;
          CFG_WINDUP: windup_q <= cfg_data_i[DataWidth-2:0];
          CFG_DMIN:   dmin_q   <= cfg_data_i;
          CFG_DMAX:   dmax_q   <= cfg_data_i;
          CFG_TICK:   tick_q   <= cfg_data_i;
          default:    ;
        endcase
      end
      if (cmd_i.accept) begin
        last_time_q <= sample_time_i;
      end
      if (cmd_i.ld_diff) begin
        last_err_q <= err_q;
      end
      if (cmd_i.ld_integ) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ticks_q <= sample_time_i - last_time_q;
      err_q   <= sat_add({target_q[DataWidth-1], target_q}
                       - {measured_i[DataWidth-1], measured_i});
    end
    if (cmd_i.ld_diff) begin
      diff_q <= sat_add({err_q[DataWidth-1], err_q} - {last_err_q[DataWidth-1], last_err_q});
    end
    if (cmd_i.mul_en) begin
      prod_q    <= mul_a * mul_b;
      mul_neg_q <= mul_neg;
    end
    if (cmd_i.ld_dt) begin
      dt_q <= dt_d;
    end
    if (cmd_i.ld_p) begin
      p_q <= cap;
    end
    if (cmd_i.ld_pi) begin
      pi_q <= sat_add({p_q[DataWidth-1], p_q} + {cap[DataWidth-1], cap});
    end
    if (cmd_i.ld_out) begin
      drive_q <= y_clamp;
    end
  end

  pidts_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({mag(diff_q), {FracBits{1'b0}}}),
    .divisor_i  (dt_q),
    .quotient_o (quotient),
    .busy_o     (div_busy)
  );

  assign sts_o.first    = (last_time_q == '0);
  assign sts_o.dt_zero  = (dt_q == '0);
  assign sts_o.div_busy = div_busy;
  assign drive_o        = drive_q;

endmodule

FILE: hdl/pidts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidts_ctrl
// Sequencer: issues multiplier, divider and load commands per sample.
// ----------------------------------------------------------------------------
module pidts_ctrl import pidts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  pidts_sts_t sts_i,
  output pidts_cmd_t cmd_o
);

  pidts_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i && !sts_i.first) state_d = ST_TDT;
      ST_TDT:   state_d = ST_PROP;
      ST_PROP:  state_d = ST_EDT;
      ST_EDT:   state_d = ST_INTEG;
      ST_INTEG: state_d = ST_MUL_I;
      ST_MUL_I: state_d = ST_CAP_I;
      ST_CAP_I: state_d = sts_i.dt_zero ? ST_OUT : ST_DIV;
      ST_DIV:   if (!sts_i.div_busy) state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mul_sel = MS_TICK;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_TDT: begin
        cmd_o.ld_diff = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_TICK;
      end
      ST_PROP: begin
        cmd_o.ld_dt   = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_PROP;
      end
      ST_EDT: begin
        cmd_o.ld_p    = 1'b1;
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_EDT;
      end
      ST_INTEG: begin
        cmd_o.ld_integ  = 1'b1;
        cmd_o.div_start = !sts_i.dt_zero;
      end
      ST_MUL_I: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_INTEG;
      end
      ST_CAP_I: begin
        cmd_o.ld_pi = 1'b1;
      end
      ST_DIV: begin
        cmd_o.mul_en  = !sts_i.div_busy;
        cmd_o.mul_sel = MS_DERIV;
      end
      ST_OUT: begin
        cmd_o.ld_out = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.ld_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.ld_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten while pending");

  a_first_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.first) |=> (state_q == ST_IDLE))
    else $error("first sample started a computation");

  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> sts_i.div_busy)
    else $error("divider did not start");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !sts_i.dt_zero)
    else $error("divider started with zero dt");

endmodule

FILE: hdl/pid_controller_timestamped_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_timestamped_unit
// Timestamped Q16.16 PID controller with integral clamp and output limits.
// ----------------------------------------------------------------------------
// A sample is taken only while the sequencer is idle. The very first sample
// (stored timestamp zero) just records its timestamp and gives no result.
// Every later sample passes through the 48-step restoring divider that forms
// the derivative quotient; when dt is zero the divider is skipped. A new
// sample is accepted only once the previous result has been loaded into
// the output register. All products go through one shared 32x32 multiplier.
// The result sits in an output register, so the next sample is taken while
// it waits.
module pid_controller_timestamped_unit import pidts_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [DataWidth-1:0]   cfg_data_i,
  pidts_in_if.sink               in_ch,
  pidts_out_if.source            out_ch
);

  pidts_cmd_t cmd;
  pidts_sts_t sts;

  pidts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_ready_i (out_ch.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pidts_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .measured_i    (in_ch.measured),
    .sample_time_i (in_ch.sample_time),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .drive_o       (out_ch.drive)
  );

endmodule

FILE: verif/pid_controller_timestamped_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_timestamped_unit_tb
// Self-checking bench for the timestamped PID unit. A directed table covers
// the range extremes, the uninitialized timestamp, zero dt, wrapping stamps,
// crossed output limits and gain extremes. Random phases follow, each with its
// own register setting and mostly increasing timestamps. Every drive result
// is checked against a bit-exact Q16.16 predictor or a directed row's typed value.
// Sender bursts and receiver stall patterns vary the handshake timing.
// ----------------------------------------------------------------------------
module pid_controller_timestamped_unit_tb;
  import pidts_pkg::*;

  localparam int     HalfPeriod   = 5;
  localparam int     SettleCycles = 120;
  localparam int     StallLimit   = 4000;
  localparam int     NumPhases    = 10;
  localparam int     PhaseItems   = 140;
  localparam int     HoldCycles   = 800;
  localparam int     HoldAfter    = 200;
  localparam longint QMax         = 64'sd2147483647;
  localparam longint QMin         = -QMax - 1;

  typedef struct packed {
    logic       is_cfg;
    pidts_cfg_e sel;
    logic [31:0] value;      // register data, or measured for a sample
    logic [31:0] stamp;
    logic        typed;
    logic [31:0] drive;
  } plan_row_t;

  localparam int NumPlan = 45;
  localparam plan_row_t DirectedPlan [NumPlan] = '{
    // reset setting: all gains zero, drive clamped to [0, 0]
    '{1'b0, CFG_TARGET, 32'h0000_0000, 32'd0,   1'b0, 32'h0},  // stamp zero: stays uninit
    '{1'b0, CFG_TARGET, 32'h7FFF_FFFF, 32'd100, 1'b0, 32'h0},  // first sample
    '{1'b0, CFG_TARGET, 32'h8000_0000, 32'd200, 1'b1, 32'h0},
    '{1'b1, CFG_DMIN,   32'h8000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_DMAX,   32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KP,     32'h0001_0000, 32'd0,   1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h0001_0000, 32'd300, 1'b1, 32'hFFFF_0000},
    '{1'b0, CFG_TARGET, 32'h8000_0000, 32'd400, 1'b1, 32'h7FFF_FFFF},
    '{1'b0, CFG_TARGET, 32'h7FFF_FFFF, 32'd400, 1'b1, 32'h8000_0001},  // zero dt
    // all gains at positive extreme
    '{1'b1, CFG_TARGET, 32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KP,     32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KI,     32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KD,     32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_WINDUP, 32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h7FFF_FFFF, 32'h0000_0005, 1'b0, 32'h0},  // wraps forward
    '{1'b0, CFG_TARGET, 32'h0000_0000, 32'h0000_0003, 1'b0, 32'h0},  // goes backwards
    '{1'b0, CFG_TARGET, 32'h1234_5678, 32'h0000_0003, 1'b0, 32'h0},  // equal stamps
    '{1'b0, CFG_TARGET, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0},  // back to uninit
    '{1'b0, CFG_TARGET, 32'h0000_0001, 32'h0000_0007, 1'b0, 32'h0},  // first again
    // all gains at negative extreme, longest tick
    '{1'b1, CFG_TARGET, 32'h8000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KP,     32'h8000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KI,     32'h8000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KD,     32'h8000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_TICK,   32'hFFFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_WINDUP, 32'h0001_0000, 32'd0,   1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h7FFF_FFFF, 32'h0000_0008, 1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h8000_0000, 32'h0001_0008, 1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'hFFFF_FFFF, 32'h0001_0009, 1'b0, 32'h0},
    // crossed output limits, tick period zero
    '{1'b1, CFG_DMIN,   32'h0001_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_DMAX,   32'hFFFF_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_TICK,   32'h0000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h0000_0000, 32'h0002_0000, 1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h4000_0000, 32'h0003_0000, 1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'hC000_0000, 32'h0004_0000, 1'b0, 32'h0},
    // shortest tick, moderate gains
    '{1'b1, CFG_TICK,   32'h0000_0001, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KP,     32'h0002_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KI,     32'h0000_8000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_KD,     32'h0000_0100, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_DMIN,   32'h8000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_DMAX,   32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_TARGET, 32'h0000_0000, 32'd0,   1'b0, 32'h0},
    '{1'b1, CFG_WINDUP, 32'h7FFF_FFFF, 32'd0,   1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'h0000_1000, 32'h0005_0000, 1'b0, 32'h0},
    '{1'b0, CFG_TARGET, 32'hFFFF_0000, 32'h0006_0000, 1'b0, 32'h0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [DataWidth-1:0]   cfg_data_i;

  pidts_in_if  in_ch ();
  pidts_out_if out_ch ();

  pid_controller_timestamped_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // predictor copy of registers and controller state
  logic signed [31:0] sp_q, kp_q, ki_q, kd_q, dmin_q, dmax_q;
  logic [30:0]        windup_q;
  logic [31:0]        tick_q;
  logic [31:0]        last_stamp_q;
  logic signed [31:0] last_err_q, integ_q;

  logic [31:0] pending_drive [$];
  int          mismatch_count;
  int          drive_count;
  int          idle_cycles;
  int          burst_left;
  bit          held;

  initial clk_i = 1'b0;
  always #HalfPeriod clk_i = ~clk_i;

  function automatic longint sat32(input longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // (a*b) >> 16, truncated toward zero, saturated
  function automatic longint fx_mul(input longint a, input longint b);
    bit              neg;
    longint unsigned ua, ub, pr, lim;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? -a : a;
    ub  = (b < 0) ? -b : b;
    pr  = (ua * ub) >> FracBits;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (pr > lim) pr = lim;
    return neg ? -longint'(pr) : longint'(pr);
  endfunction

  // (num << 16) / den, truncated toward zero, saturated
  function automatic longint fx_div(input longint num, input longint unsigned den);
    bit              neg;
    longint unsigned un, q, lim;
    neg = num < 0;
    un  = neg ? -num : num;
    q   = (un << FracBits) / den;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (q > lim) q = lim;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic bit predict_drive(input logic [31:0] meas, input logic [31:0] stamp,
                                       output logic [31:0] drv);
    logic [31:0]     tdiff;
    longint unsigned ticks, dtv;
    longint          e, lim, acc, p, iv, d, y;
    drv = '0;
    if (last_stamp_q == '0) begin
      last_stamp_q = stamp;
      return 1'b0;
    end
    tdiff = stamp - last_stamp_q;
    ticks = tdiff;
    dtv   = (ticks * longint'({32'd0, tick_q})) >> (32 - FracBits);
    if (dtv > QMax) dtv = QMax;
    last_stamp_q = stamp;

    e   = sat32(longint'(sp_q) - longint'(signed'(meas)));
    acc = sat32(longint'(integ_q) + fx_mul(e, dtv));
    lim = longint'({33'd0, windup_q});
    if (acc > lim) acc = lim;
    else if (acc < -lim) acc = -lim;
    integ_q = acc[31:0];

    p  = fx_mul(e, longint'(kp_q));
    iv = fx_mul(acc, longint'(ki_q));
    d  = 0;
    if (dtv != 0) d = fx_mul(fx_div(sat32(e - longint'(last_err_q)), dtv), longint'(kd_q));
    last_err_q = e[31:0];

    y = sat32(sat32(p + iv) + d);
    if (y > longint'(dmax_q)) y = longint'(dmax_q);
    else if (y < longint'(dmin_q)) y = longint'(dmin_q);
    drv = y[31:0];
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ERROR %s: drive %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // entered at a falling edge; the register is written at the next rising edge
  task automatic write_reg(input pidts_cfg_e sel, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= val;
    case (sel)
      CFG_TARGET: sp_q     = val;
      CFG_KP:     kp_q     = val;
      CFG_KI:     ki_q     = val;
      CFG_KD:     kd_q     = val;
      CFG_WINDUP: windup_q = val[30:0];
      CFG_DMIN:   dmin_q   = val;
      CFG_DMAX:   dmax_q   = val;
      CFG_TICK:   tick_q   = val;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // entered at a falling edge, returns at the falling edge after acceptance
  task automatic put_sample(input logic [31:0] meas, input logic [31:0] stamp,
                            input bit typed, input logic [31:0] typed_drive);
    logic [31:0] pd;
    in_ch.valid       <= 1'b1;
    in_ch.measured    <= meas;
    in_ch.sample_time <= stamp;
    do @(posedge clk_i); while (!in_ch.ready);
    if (predict_drive(meas, stamp, pd)) pending_drive.push_back(typed ? typed_drive : pd);
    @(negedge clk_i);
  endtask

  task automatic pace(input int gap_mode);
    int gap;
    if (gap_mode == 0) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = (gap_mode == 3) ? $urandom_range(0, 150) : $urandom_range(0, 70);
      burst_left = $urandom_range(0, 25);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_drive.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rnd_q(input int lo_sh, input int hi_sh);
    case ($urandom_range(0, 11))
      0:       return MinVal;
      1:       return MaxVal;
      2:       return $urandom_range(0, 2) == 0 ? 32'h0 : 32'hFFFF_FFFF;
      default: return signed'($urandom) >>> $urandom_range(lo_sh, hi_sh);
    endcase
  endfunction

  task automatic random_setting();
    logic signed [31:0] a, b;
    logic [31:0]        tick;
    write_reg(CFG_TARGET, rnd_q(0, 20));
    write_reg(CFG_KP, rnd_q(6, 24));
    write_reg(CFG_KI, rnd_q(6, 24));
    write_reg(CFG_KD, rnd_q(6, 24));
    case ($urandom_range(0, 5))
      0:       write_reg(CFG_WINDUP, 32'h0);
      1:       write_reg(CFG_WINDUP, 32'h7FFF_FFFF);
      default: write_reg(CFG_WINDUP, $urandom >> $urandom_range(1, 31));
    endcase
    a = rnd_q(0, 16);
    b = rnd_q(0, 16);
    case ($urandom_range(0, 7))
      0: begin
        write_reg(CFG_DMIN, MinVal);
        write_reg(CFG_DMAX, MaxVal);
      end
      1: begin
        write_reg(CFG_DMIN, a);
        write_reg(CFG_DMAX, b);
      end
      default: begin
        write_reg(CFG_DMIN, (a < b) ? a : b);
        write_reg(CFG_DMAX, (a < b) ? b : a);
      end
    endcase
    case ($urandom_range(0, 5))
      0: tick = TickPeriodRst;
      1: tick = $urandom;
      2: tick = 32'd1;
      3: tick = 32'hFFFF_FFFF;
      default: begin
        tick = $urandom >> $urandom_range(0, 28);
        if (tick == '0) tick = 32'd1;
      end
    endcase
    write_reg(CFG_TICK, tick);
    cfg_we_i <= 1'b0;
  endtask

  // result check
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      drive_count++;
      if (pending_drive.size() == 0) begin
        report_mismatch("result with no pending sample", out_ch.drive, 'x);
      end else begin
        want = pending_drive.pop_front();
        if (out_ch.drive !== want) report_mismatch("wrong result", out_ch.drive, want);
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int seg, mode, cyc;
    out_ch.ready = 1'b0;
    held         = 1'b0;
    cyc          = 0;
    forever begin
      seg  = $urandom_range(20, 300);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(negedge clk_i);
        cyc++;
        if (!held && drive_count >= HoldAfter) begin
          held = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HoldCycles - 1) @(negedge clk_i);
        end else begin
          case (mode)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= $urandom_range(0, 1);
            2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
            default: out_ch.ready <= (cyc % 16) < 5;
          endcase
        end
      end
    end
  end

  initial begin
    bit          cfg_open;
    int          gap_mode;
    logic [31:0] stamp, meas;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_ch.valid       = 1'b0;
    in_ch.measured    = '0;
    in_ch.sample_time = '0;
    mismatch_count    = 0;
    drive_count       = 0;
    idle_cycles       = 0;
    burst_left        = 0;
    sp_q = '0; kp_q = '0; ki_q = '0; kd_q = '0; windup_q = '0;
    dmin_q = '0; dmax_q = '0; tick_q = TickPeriodRst;
    last_stamp_q = '0; last_err_q = '0; integ_q = '0;

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cfg_open = 1'b0;
    foreach (DirectedPlan[n]) begin
      if (DirectedPlan[n].is_cfg) begin
        if (!cfg_open) begin
          wait_idle();
          cfg_open = 1'b1;
        end
        write_reg(DirectedPlan[n].sel, DirectedPlan[n].value);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        put_sample(DirectedPlan[n].value, DirectedPlan[n].stamp,
                   DirectedPlan[n].typed, DirectedPlan[n].drive);
        pace(1);
      end
    end

    stamp = 32'd1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      random_setting();
      gap_mode   = $urandom_range(0, 3);
      burst_left = 0;
      for (int k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 49))
          0:       ;                                        // equal stamps
          1:       stamp = stamp - $urandom_range(1, 1000);  // backwards
          2:       stamp = $urandom;
          3:       stamp = '0;                              // drops back to uninit
          4, 5:    stamp = stamp + ($urandom >> $urandom_range(8, 31));
          default: stamp = stamp + $urandom_range(1, 3000);
        endcase
        case ($urandom_range(0, 9))
          0:       meas = $urandom;
          1:       meas = rnd_q(0, 0);
          default: meas = sp_q + rnd_q(4, 24);
        endcase
        put_sample(meas, stamp, 1'b0, '0);
        pace(gap_mode);
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: pid_controller_timestamped_unit.f
hdl/pidts_pkg.sv
hdl/pidts_in_if.sv
hdl/pidts_out_if.sv
hdl/pidts_div.sv
hdl/pidts_datapath.sv
hdl/pidts_ctrl.sv
hdl/pid_controller_timestamped_unit.sv
verif/pid_controller_timestamped_unit_tb.sv
